// ===== hw/rtl/tbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared constants, types and LFSR and counter helpers of the TAGE branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

	localparam int TABLES    = 6;
	localparam int NTAGGED   = TABLES - 1;
	localparam int ENTRIES   = 4096;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int TAG_BITS  = 10;
	localparam int HIST_BITS = 128;
	localparam int LEN_W     = $clog2(HIST_BITS + 1);
	localparam int ADDR_W    = 30;
	localparam int PW_W      = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;
	localparam int TBL_W     = (NTAGGED > 1) ? $clog2(NTAGGED) : 1;
	localparam int CNT_W     = $clog2(NTAGGED + 1);
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIST_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PC_BITS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_PROB = 2'd3;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic                valid;
		logic [1:0]          ctr;
		logic [1:0]          u;
	} entry_t;

	// One tagged table entry write.
	typedef struct packed {
		logic       we;
		logic [IDX_W-1:0] idx;
		entry_t     data;
	} wr_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		logic b;
		b = s[0] ^ s[2] ^ s[3] ^ s[5];
		return {b, s[15:1]};
	endfunction

	function automatic logic [1:0] ctr_upd(input logic [1:0] c, input logic t);
		logic [1:0] r;
		r = c;
		if (t) begin
			if (c != 2'd3) r = c + 2'd1;
		end else begin
			if (c != 2'd0) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/tbp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_br_if / tbp_res_if
// Valid/ready channels for resolved branches and prediction results.
// ----------------------------------------------------------------------------
interface tbp_br_if;
	logic                      valid;
	logic                      ready;
	logic [tbp_pkg::ADDR_W-1:0] branch_addr;
	logic                      taken;
	modport source (output valid, output branch_addr, output taken, input ready);
	modport sink   (input valid, input branch_addr, input taken, output ready);
endinterface

interface tbp_res_if;
	logic valid;
	logic ready;
	logic prediction;
	logic correct;
	modport source (output valid, output prediction, output correct, input ready);
	modport sink   (input valid, input prediction, input correct, output ready);
endinterface

// ===== hw/rtl/tbp_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_hash
// Bit-serial history folder: one history bit per cycle into the folds of every table whose length covers it.
// ----------------------------------------------------------------------------
module tbp_hash (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tbp_pkg::HIST_BITS-1:0]     hist,
	input  logic [tbp_pkg::LEN_W-1:0]         lens [tbp_pkg::NTAGGED],
	input  logic [tbp_pkg::LEN_W-1:0]         max_len,
	input  logic [tbp_pkg::PW_W-1:0]          pw,
	input  logic [tbp_pkg::ADDR_W-1:0]        pc,
	output logic                              done,
	output logic [tbp_pkg::IDX_W-1:0]         idx [tbp_pkg::NTAGGED],
	output logic [tbp_pkg::TAG_BITS-1:0]      tag [tbp_pkg::NTAGGED]
);
	localparam int TB = tbp_pkg::TAG_BITS;

	logic                      busy_q;
	logic [tbp_pkg::LEN_W-1:0] i_q;
	logic [tbp_pkg::PW_W-1:0]  pi_q;
	logic [$clog2(TB)-1:0]     p1_q;
	logic [$clog2(TB)-1:0]     p2_q;
	logic [tbp_pkg::ADDR_W-1:0] fi_q [tbp_pkg::NTAGGED];
	logic [TB-1:0]             f1_q [tbp_pkg::NTAGGED];
	logic [TB-1:0]             f2_q [tbp_pkg::NTAGGED];
	logic                      hb;

	assign hb = hist[i_q[$clog2(tbp_pkg::HIST_BITS)-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
			pi_q   <= '0;
			p1_q   <= '0;
			p2_q   <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				pi_q   <= '0;
				p1_q   <= '0;
				p2_q   <= '0;
				for (int t = 0; t < tbp_pkg::NTAGGED; t++) begin
					fi_q[t] <= '0;
					f1_q[t] <= '0;
					f2_q[t] <= '0;
				end
			end else if (busy_q) begin
				if (i_q == max_len) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					for (int t = 0; t < tbp_pkg::NTAGGED; t++) begin
						if (i_q < lens[t]) begin
							fi_q[t][pi_q] <= fi_q[t][pi_q] ^ hb;
							f1_q[t][p1_q] <= f1_q[t][p1_q] ^ hb;
							f2_q[t][p2_q] <= f2_q[t][p2_q] ^ hb;
						end
					end
					i_q  <= i_q + 1'b1;
					pi_q <= (pi_q + 1'b1 == pw) ? '0 : pi_q + 1'b1;
					p1_q <= (32'(p1_q) + 1 == TB) ? '0 : p1_q + 1'b1;
					p2_q <= (32'(p2_q) + 1 == TB - 1) ? '0 : p2_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int t = 0; t < tbp_pkg::NTAGGED; t++) begin
			idx[t] = pc[tbp_pkg::IDX_W-1:0] ^ fi_q[t][tbp_pkg::IDX_W-1:0];
			tag[t] = pc[TB-1:0] ^ f1_q[t] ^ {f2_q[t][TB-2:0], 1'b0};
		end
	end
endmodule

// ===== hw/rtl/tbp_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_table
// One tagged table bank: synchronous RAM plus a valid/counter clearing pass.
// ----------------------------------------------------------------------------
module tbp_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [tbp_pkg::IDX_W-1:0]     rd_idx,
	output tbp_pkg::entry_t               rd_data,
	input  tbp_pkg::wr_t                  wr,
	output logic                          clr_busy
);
	tbp_pkg::entry_t mem [tbp_pkg::ENTRIES];
	logic [tbp_pkg::IDX_W:0] clr_q;

	assign clr_busy = !clr_q[tbp_pkg::IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem[clr_q[tbp_pkg::IDX_W-1:0]] <= '0;
		end else if (wr.we) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end
endmodule

// ===== hw/rtl/tage_branch_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tage_branch_predictor
// TAGE predictor trained with one resolved branch per beat.
// ----------------------------------------------------------------------------
// Usage:
//   br  (sink):   one resolved branch per beat: branch_addr, taken.
//   res (source): one beat per branch: prediction made before training and
//                 whether it matched the outcome.
//   cfg_we/cfg_idx/cfg_data: register writes, only while idle.
// Timing: a branch beat passes through S_HASH, S_READ, S_DEC, S_DRAW,
//   S_WRITE and S_OUT, which sets the result valid; the next branch is taken
//   only back in S_IDLE. S_HASH folds the history one bit per cycle up to
//   max_len, the longest tagged history length (up to 128), into the table
//   hashes; then base and tagged banks are read in parallel, decided, and
//   written back. A mispredict with two or more candidates adds S_MOD1 for
//   the draw mod alloc_prob, and S_MOD2 when a second draw picks a candidate
//   (serial remainder, one dividend bit per cycle).
// Reset: resets history, LFSR and registers, then a clearing pass over
//   all ENTRIES (4096) entries wipes all banks; no branch is taken meanwhile.
// Stall: the result sits in an output register; the next branch is taken
//   while it waits, but its result is held back until the first one leaves.
// ----------------------------------------------------------------------------
module tage_branch_predictor (
	input  logic                              clk,
	input  logic                              arst_n,
	tbp_br_if.sink                            br,
	tbp_res_if.source                         res,
	input  logic                              cfg_we,
	input  logic [tbp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tbp_pkg::CFG_DAT_W-1:0]     cfg_data
);
	localparam int NT = tbp_pkg::NTAGGED;
	localparam int IW = tbp_pkg::IDX_W;
	localparam int LW = tbp_pkg::LEN_W;

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_READ, S_DEC, S_MOD1, S_MOD2, S_DRAW, S_WRITE, S_OUT
	} st_t;

	st_t st_q;
	logic [7:0] first_len_q;
	logic [4:0] ratio_q;
	logic [4:0] pcbits_q;
	logic [7:0] prob_q;
	logic [tbp_pkg::HIST_BITS-1:0] hist_q;
	logic [15:0] lfsr_q;
	logic [tbp_pkg::ADDR_W-1:0] pc_q;
	logic taken_q;

	// ---- configuration and derived lengths ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q <= 8'd4;
			ratio_q     <= 5'd2;
			pcbits_q    <= 5'd12;
			prob_q      <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_idx)
				tbp_pkg::CFG_FIRST_LEN:  first_len_q <= cfg_data;
				tbp_pkg::CFG_HIST_RATIO: ratio_q     <= cfg_data[4:0];
				tbp_pkg::CFG_PC_BITS:    pcbits_q    <= cfg_data[4:0];
				tbp_pkg::CFG_ALLOC_PROB: prob_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [LW-1:0] lens [NT];
	logic [LW-1:0] max_len;
	logic [4:0]    pw;
	always_comb begin
		logic [7:0]  l1;
		logic [4:0]  r;
		logic [12:0] p;
		l1 = (first_len_q == 0) ? 8'd1 : first_len_q;
		r  = (ratio_q == 0) ? 5'd1 : ratio_q;
		lens[0] = (l1 > 8'(tbp_pkg::HIST_BITS)) ? LW'(tbp_pkg::HIST_BITS) : LW'(l1);
		for (int t = 1; t < NT; t++) begin
			p = 13'(lens[t-1]) * 13'(r);
			lens[t] = (p > 13'(tbp_pkg::HIST_BITS)) ? LW'(tbp_pkg::HIST_BITS) : LW'(p);
		end
		max_len = lens[NT-1];
		pw = (pcbits_q == 0) ? 5'd1 : ((pcbits_q > 5'd30) ? 5'd30 : pcbits_q);
	end

	// ---- hash unit ----
	logic hash_start, hash_done;
	logic [IW-1:0] idx [NT];
	logic [tbp_pkg::TAG_BITS-1:0] tag [NT];
	tbp_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start), .hist(hist_q),
		.lens(lens), .max_len(max_len), .pw(pw), .pc(pc_q),
		.done(hash_done), .idx(idx), .tag(tag)
	);

	// ---- memories ----
	logic rd_en;
	tbp_pkg::entry_t rd [NT];
	tbp_pkg::wr_t    wr [NT];
	logic [NT-1:0]   clr;
	for (genvar g = 0; g < NT; g++) begin : g_tbl
		tbp_table u_tbl (
			.clk(clk), .arst_n(arst_n), .rd_en(rd_en), .rd_idx(idx[g]),
			.rd_data(rd[g]), .wr(wr[g]), .clr_busy(clr[g])
		);
	end

	logic [1:0] base_mem [tbp_pkg::ENTRIES];
	logic [1:0] base_rd;
	logic       base_we;
	logic [1:0] base_wd;
	logic [IW-1:0] bidx;
	assign bidx = pc_q[IW-1:0];
	always_ff @(posedge clk) begin
		if (clr[0]) begin
			base_mem[g_tbl[0].u_tbl.clr_q[IW-1:0]] <= 2'd0;
		end else if (base_we) begin
			base_mem[bidx] <= base_wd;
		end
		if (rd_en) base_rd <= base_mem[bidx];
	end

	// ---- decision ----
	logic [NT-1:0] hit;
	logic          found, pred, alt;
	logic [tbp_pkg::TBL_W-1:0] prov;
	always_comb begin
		logic second;
		found = 1'b0; second = 1'b0;
		pred = base_rd[1]; alt = base_rd[1]; prov = '0;
		for (int t = NT - 1; t >= 0; t--) begin
			hit[t] = rd[t].valid && (rd[t].tag == tag[t]);
			if (hit[t] && !second) begin
				if (!found) begin
					found = 1'b1; prov = tbp_pkg::TBL_W'(t); pred = rd[t].ctr[1];
				end else begin
					second = 1'b1; alt = rd[t].ctr[1];
				end
			end
		end
	end

	logic pred_s1, found_s1, alt_s1;
	logic [tbp_pkg::TBL_W-1:0] prov_s1;
	logic [NT-1:0] cand_s1;
	logic [tbp_pkg::CNT_W-1:0] ncand_s1;
	logic [tbp_pkg::TBL_W-1:0] ch_q;
	logic alloc_q;

	// serial remainder: one dividend bit per cycle, MSB first
	logic [15:0] dvd_q;
	logic [7:0]  div_q;
	logic [7:0]  rem_q;
	logic [3:0]  cnt_q;
	logic        use_pick_q;
	logic [tbp_pkg::CNT_W-1:0] k_q;
	logic [8:0]  rem_sh;
	logic [7:0]  rem_nx;
	assign rem_sh = {rem_q, dvd_q[15]};
	assign rem_nx = (rem_sh >= {1'b0, div_q}) ? 8'(rem_sh - {1'b0, div_q}) : rem_sh[7:0];

	logic res_valid_q, res_pred_q, res_corr_q;
	assign res.valid      = res_valid_q;
	assign res.prediction = res_pred_q;
	assign res.correct    = res_corr_q;
	assign br.ready       = (st_q == S_IDLE) && !(|clr);

	assign hash_start = br.valid && br.ready;
	assign rd_en      = (st_q == S_HASH) && hash_done;

	// candidate of ordinal k_q (second draw)
	logic [tbp_pkg::TBL_W-1:0] pick;
	always_comb begin
		logic [tbp_pkg::CNT_W-1:0] seen;
		seen = '0; pick = '0;
		for (int t = 0; t < NT; t++) begin
			if (cand_s1[t]) begin
				if (seen == k_q) pick = tbp_pkg::TBL_W'(t);
				seen = seen + 1'b1;
			end
		end
	end

	logic [tbp_pkg::TBL_W-1:0] first_cand;
	always_comb begin
		first_cand = '0;
		for (int t = NT - 1; t >= 0; t--) if (cand_s1[t]) first_cand = tbp_pkg::TBL_W'(t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			hist_q      <= '0;
			lfsr_q      <= tbp_pkg::LFSR_SEED;
			res_valid_q <= 1'b0;
			alloc_q     <= 1'b0;
			rem_q       <= '0;
			cnt_q       <= '0;
			use_pick_q  <= 1'b0;
		end else begin
			if (st_q == S_OUT && (!res_valid_q || res.ready)) res_valid_q <= 1'b1;
			else if (res_valid_q && res.ready) res_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (hash_start) begin
					pc_q    <= br.branch_addr & ((30'd1 << pw) - 30'd1);
					taken_q <= br.taken;
					st_q    <= S_HASH;
				end
				S_HASH: if (hash_done) st_q <= S_READ;
				S_READ: st_q <= S_DEC;
				S_DEC: begin
					logic [tbp_pkg::CNT_W-1:0] n;
					n = '0;
					for (int t = 0; t < NT; t++) begin
						cand_s1[t] <= (!found || tbp_pkg::TBL_W'(t) > prov) && rd[t].u == 2'd0;
						if ((!found || tbp_pkg::TBL_W'(t) > prov) && rd[t].u == 2'd0) n = n + 1'b1;
					end
					ncand_s1   <= n;
					pred_s1    <= pred;
					alt_s1     <= alt;
					found_s1   <= found;
					prov_s1    <= prov;
					use_pick_q <= 1'b0;
					dvd_q      <= tbp_pkg::lfsr_next(lfsr_q);
					div_q      <= (prob_q == 0) ? 8'd1 : prob_q;
					rem_q      <= '0;
					cnt_q      <= '0;
					if (pred != taken_q && n > 1) begin
						lfsr_q <= tbp_pkg::lfsr_next(lfsr_q);
						st_q   <= S_MOD1;
					end else begin
						st_q <= S_DRAW;
					end
				end
				// first draw mod alloc_prob; zero means a second draw
				S_MOD1: begin
					if (cnt_q == 4'd15) begin
						cnt_q <= '0;
						rem_q <= '0;
						if (rem_nx == 8'd0) begin
							lfsr_q <= tbp_pkg::lfsr_next(lfsr_q);
							dvd_q  <= tbp_pkg::lfsr_next(lfsr_q);
							div_q  <= 8'(ncand_s1) - 8'd1;
							st_q   <= S_MOD2;
						end else begin
							st_q <= S_DRAW;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
						rem_q <= rem_nx;
						dvd_q <= {dvd_q[14:0], 1'b0};
					end
				end
				// second draw mod (candidates - 1) gives the ordinal minus one
				S_MOD2: begin
					if (cnt_q == 4'd15) begin
						cnt_q      <= '0;
						rem_q      <= '0;
						k_q        <= tbp_pkg::CNT_W'(rem_nx) + tbp_pkg::CNT_W'(1);
						use_pick_q <= 1'b1;
						st_q       <= S_DRAW;
					end else begin
						cnt_q <= cnt_q + 4'd1;
						rem_q <= rem_nx;
						dvd_q <= {dvd_q[14:0], 1'b0};
					end
				end
				S_DRAW: begin
					alloc_q <= (pred_s1 != taken_q) && (ncand_s1 != 0);
					ch_q    <= use_pick_q ? pick : first_cand;
					st_q    <= S_WRITE;
				end
				S_WRITE: begin
					hist_q <= {hist_q[tbp_pkg::HIST_BITS-2:0], taken_q};
					st_q   <= S_OUT;
				end
				S_OUT: if (!res_valid_q || res.ready) begin
					res_pred_q  <= pred_s1;
					res_corr_q  <= pred_s1 == taken_q;
					st_q        <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// write-back, all banks in S_WRITE
	always_comb begin
		logic pc_ok, alt_ok;
		pc_ok = pred_s1 == taken_q;
		alt_ok = alt_s1 == taken_q;
		base_we = (st_q == S_WRITE) && !found_s1;
		base_wd = tbp_pkg::ctr_upd(base_rd, taken_q);
		for (int t = 0; t < NT; t++) begin
			wr[t].we   = 1'b0;
			wr[t].idx  = idx[t];
			wr[t].data = rd[t];
			if (found_s1 && tbp_pkg::TBL_W'(t) == prov_s1) begin
				wr[t].we = 1'b1;
				wr[t].data.ctr = tbp_pkg::ctr_upd(rd[t].ctr, taken_q);
				if (pc_ok && !alt_ok && rd[t].u != 2'd3) wr[t].data.u = rd[t].u + 2'd1;
				else if (!pc_ok && alt_ok && rd[t].u != 2'd0) wr[t].data.u = rd[t].u - 2'd1;
			end
			if (!pc_ok && (!found_s1 || tbp_pkg::TBL_W'(t) > prov_s1)) begin
				if (alloc_q) begin
					if (tbp_pkg::TBL_W'(t) == ch_q) begin
						wr[t].we = 1'b1;
						wr[t].data.tag = tag[t];
						wr[t].data.valid = 1'b1;
						wr[t].data.ctr = taken_q ? 2'd2 : 2'd1;
						wr[t].data.u = 2'd0;
					end
				end else if (rd[t].u != 2'd0) begin
					wr[t].we = 1'b1;
					wr[t].data.u = rd[t].u - 2'd1;
				end
			end
			if (st_q != S_WRITE) wr[t].we = 1'b0;
		end
	end

	// ---- assertions ----
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !br.ready) else $error("accept while busy");
	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (st_q == S_HASH)) else $error("hash done out of place");
	a_write_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WRITE) |-> $past(st_q) == S_DRAW) else $error("bad sequence");
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TAGE branch predictor. Resolved branches are
// sent through the branch channel. A behavioral predictor keeps its own copy
// of the tables, the history and the allocation LFSR, and predicts each
// result beat. The result checker compares every beat with the oldest
// expected prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import tbp_pkg::*;

	localparam int PERIOD = 12;

	// expected result of one branch
	typedef struct {
		logic prediction;
		logic correct;
	} outcome_t;

	// one tagged table slot as the bench tracks it
	typedef struct {
		logic [TAG_BITS-1:0] tag;
		logic                valid;
		logic [1:0]          ctr;
		logic [1:0]          u;
	} slot_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DAT_W-1:0] cfg_data;

	tbp_br_if  br_ch ();
	tbp_res_if res_ch ();

	tage_branch_predictor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.br       (br_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// ---------------------------------------------------------------- shadow state
	// Mirror of the predictor: base counters, tagged slots, history, LFSR
	// and the four registers as last written.
	logic [1:0]         base_ctr [ENTRIES];
	slot_t              slots    [NTAGGED][ENTRIES];
	logic [HIST_BITS-1:0] ghist;
	logic [15:0]        alloc_lfsr;
	logic [7:0]         reg_first_len;
	logic [4:0]         reg_ratio;
	logic [4:0]         reg_pc_bits;
	logic [7:0]         reg_alloc_prob;

	outcome_t pending_results [$];
	int       mismatches;
	bit       no_idle;       // when set, neither side inserts gaps
	bit       hold_request;  // asks the result side for one long hold-off

	// --------------------------------------------------------------- clock/reset
	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// --------------------------------------------------------------- predictor
	function automatic logic [15:0] step_lfsr();
		logic fb;
		fb = alloc_lfsr[0] ^ alloc_lfsr[2] ^ alloc_lfsr[3] ^ alloc_lfsr[5];
		alloc_lfsr = {fb, alloc_lfsr[15:1]};
		return alloc_lfsr;
	endfunction

	// history length of tagged table t, zero registers read as one
	function automatic int hist_len(int t);
		int l1, r, len;
		l1 = (reg_first_len == 0) ? 1 : reg_first_len;
		r = (reg_ratio == 0) ? 1 : reg_ratio;
		len = (l1 > HIST_BITS) ? HIST_BITS : l1;
		for (int k = 0; k < t; k++) begin
			len = len * r;
			if (len > HIST_BITS) len = HIST_BITS;
		end
		return len;
	endfunction

	// fold the history into an index and a tag for table t
	task automatic fold_hash(input int t, input logic [31:0] pc, input int pw,
			output logic [IDX_W-1:0] idx, output logic [TAG_BITS-1:0] tag);
		int len, pi, p1, p2;
		logic [31:0] fi, f1, f2;
		len = hist_len(t);
		fi = 0; f1 = 0; f2 = 0;
		pi = 0; p1 = 0; p2 = 0;
		for (int i = 0; i < len; i++) begin
			fi ^= 32'(ghist[i]) << pi;
			f1 ^= 32'(ghist[i]) << p1;
			f2 ^= 32'(ghist[i]) << p2;
			if (++pi == pw) pi = 0;
			if (++p1 == TAG_BITS) p1 = 0;
			if (++p2 == TAG_BITS - 1) p2 = 0;
		end
		idx = IDX_W'(pc ^ fi);
		tag = TAG_BITS'(pc ^ f1 ^ (f2 << 1));
	endtask

	// predict one resolved branch, then train the shadow tables
	task automatic predict_and_train(input logic [ADDR_W-1:0] addr, input logic taken,
			output outcome_t res);
		int pw, provider, start, ncand, ch, prob;
		logic [31:0] pc;
		logic [IDX_W-1:0] idx [NTAGGED];
		logic [TAG_BITS-1:0] tag [NTAGGED];
		logic [IDX_W-1:0] bidx;
		logic pred, alt, found, pred_ok, alt_ok;
		int cand [NTAGGED];
		pw = (reg_pc_bits == 0) ? 1 : ((reg_pc_bits > 30) ? 30 : reg_pc_bits);
		pc = 32'(addr) & ((32'd1 << pw) - 1);
		bidx = IDX_W'(pc);
		prob = (reg_alloc_prob == 0) ? 1 : reg_alloc_prob;
		provider = -1;
		found = 1'b0;
		ncand = 0;
		pred = base_ctr[bidx] >= 2;
		alt = pred;
		for (int t = 0; t < NTAGGED; t++) fold_hash(t, pc, pw, idx[t], tag[t]);
		// longest hit provides, next shorter hit is the alternate
		for (int t = NTAGGED - 1; t >= 0; t--) begin
			if (slots[t][idx[t]].valid && slots[t][idx[t]].tag == tag[t]) begin
				if (!found) begin
					provider = t;
					pred = slots[t][idx[t]].ctr >= 2;
					found = 1'b1;
				end else begin
					alt = slots[t][idx[t]].ctr >= 2;
					break;
				end
			end
		end
		if (provider < 0) begin
			if (taken) begin
				if (base_ctr[bidx] != 3) base_ctr[bidx]++;
			end else if (base_ctr[bidx] != 0) base_ctr[bidx]--;
		end else begin
			pred_ok = pred == taken;
			alt_ok = alt == taken;
			if (taken) begin
				if (slots[provider][idx[provider]].ctr != 3) slots[provider][idx[provider]].ctr++;
			end else if (slots[provider][idx[provider]].ctr != 0) begin
				slots[provider][idx[provider]].ctr--;
			end
			if (pred_ok && !alt_ok) begin
				if (slots[provider][idx[provider]].u != 3) slots[provider][idx[provider]].u++;
			end else if (!pred_ok && alt_ok) begin
				if (slots[provider][idx[provider]].u != 0) slots[provider][idx[provider]].u--;
			end
		end
		// mispredict: allocate in a longer table or age the useful counters
		if (pred != taken) begin
			start = (provider < 0) ? 0 : provider + 1;
			for (int t = start; t < NTAGGED; t++)
				if (slots[t][idx[t]].u == 0) cand[ncand++] = t;
			if (ncand > 0) begin
				ch = cand[0];
				if (ncand > 1 && (32'(step_lfsr()) % prob) == 0)
					ch = cand[1 + int'(32'(step_lfsr()) % (ncand - 1))];
				slots[ch][idx[ch]].tag = tag[ch];
				slots[ch][idx[ch]].valid = 1'b1;
				slots[ch][idx[ch]].ctr = taken ? 2'd2 : 2'd1;
				slots[ch][idx[ch]].u = 2'd0;
			end else begin
				for (int t = start; t < NTAGGED; t++)
					if (slots[t][idx[t]].u != 0) slots[t][idx[t]].u--;
			end
		end
		ghist = {ghist[HIST_BITS-2:0], taken};
		res.prediction = pred;
		res.correct = pred == taken;
	endtask

	// --------------------------------------------------------------- drivers
	function automatic int gap_cycles();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one branch beat; valid stays high into the next beat when no gap
	task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
		int gap;
		outcome_t res;
		gap = gap_cycles();
		if (gap > 0) begin
			br_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		br_ch.valid <= 1'b1;
		br_ch.branch_addr <= addr;
		br_ch.taken <= taken;
		@(posedge clk);
		while (!br_ch.ready) @(posedge clk);
		predict_and_train(addr, taken, res);
		pending_results.insert(pending_results.size(), res);
	endtask

	// drain, then write one register while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [7:0] value);
		br_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (which)
			CFG_FIRST_LEN:  reg_first_len = value;
			CFG_HIST_RATIO: reg_ratio = value[4:0];
			CFG_PC_BITS:    reg_pc_bits = value[4:0];
			CFG_ALLOC_PROB: reg_alloc_prob = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] first_len, input logic [7:0] ratio,
			input logic [7:0] pc_bits, input logic [7:0] prob);
		write_reg(CFG_FIRST_LEN, first_len);
		write_reg(CFG_HIST_RATIO, ratio);
		write_reg(CFG_PC_BITS, pc_bits);
		write_reg(CFG_ALLOC_PROB, prob);
	endtask

	// Well-formed traffic: a small pool of loop-like branches, each with a
	// trip count, so tagged tables hit, train and allocate. About one beat
	// in five is a random address and outcome.
	task automatic random_branches(input int count);
		logic [ADDR_W-1:0] pool [16];
		int trip [16];
		int iter [16];
		int k;
		for (int i = 0; i < 16; i++) begin
			pool[i] = ADDR_W'({$urandom, $urandom});
			trip[i] = $urandom_range(1, 9);
			iter[i] = 0;
		end
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_branch(ADDR_W'({$urandom, $urandom}), 1'($urandom));
			end else begin
				k = $urandom_range(0, 15);
				send_branch(pool[k], (iter[k] % trip[k]) != trip[k] - 1);
				iter[k]++;
			end
		end
	endtask

	// --------------------------------------------------------------- result side
	// Checks every result beat and drives ready with random stalls; a hold
	// request makes it refuse results for a long counted stretch.
	initial begin : result_checker
		int stall;
		outcome_t exp_res;
		stall = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no branch outstanding");
					mismatches++;
				end else begin
					exp_res = pending_results.pop_front();
					if (res_ch.prediction !== exp_res.prediction) begin
						$error("prediction: expected %0d, got %0d",
							exp_res.prediction, res_ch.prediction);
						mismatches++;
					end
					if (res_ch.correct !== exp_res.correct) begin
						$error("correct: expected %0d, got %0d",
							exp_res.correct, res_ch.correct);
						mismatches++;
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall = 400;
			end
			if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (!no_idle) begin
					if ($urandom_range(0, 99) < 12) stall = $urandom_range(1, 3);
					else if ($urandom_range(0, 199) == 0) stall = $urandom_range(20, 60);
				end
			end
		end
	end

	// --------------------------------------------------------------- tests
	// Reset values: extremes of the address, both outcomes, repeated branches
	// so the base counters saturate and tagged entries get allocated.
	task automatic test_directed_defaults();
		send_branch('0, 1'b0);
		send_branch('0, 1'b1);
		send_branch('1, 1'b1);
		send_branch('1, 1'b0);
		send_branch(30'h2AAAAAAA, 1'b1);
		send_branch(30'h15555555, 1'b0);
		send_branch(30'h20000000, 1'b1);
		send_branch(30'h00000001, 1'b1);
		for (int i = 0; i < 12; i++) send_branch(30'h0000_0ABC, (i % 3) != 2);
	endtask

	// Register extremes, zero values read as one, fold width above 30.
	task automatic test_register_extremes();
		set_config(8'd0, 8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 6; i++) send_branch(ADDR_W'({$urandom, $urandom}), i[0]);
		set_config(8'd128, 8'd16, 8'd31, 8'd255);
		for (int i = 0; i < 6; i++) send_branch(30'h3FFF_FFF0, i[0]);
		set_config(8'd1, 8'd31, 8'd30, 8'd1);
		for (int i = 0; i < 8; i++) send_branch(30'h1234_5678 + i[1:0], i[0] ^ i[1]);
		set_config(8'd255, 8'd1, 8'd1, 8'd2);
		for (int i = 0; i < 4; i++) send_branch(ADDR_W'(i), 1'b1);
	endtask

	// Random traffic across several settings, short histories mostly.
	task automatic test_random_settings();
		set_config(8'd4, 8'd2, 8'd12, 8'd3);
		random_branches(400);
		set_config(8'd2, 8'd3, 8'd8, 8'd1);
		random_branches(350);
		no_idle = 1'b1;
		random_branches(150);
		no_idle = 1'b0;
		set_config(8'd1, 8'd1, 8'd4, 8'd2);
		random_branches(250);
		set_config(8'd128, 8'd16, 8'd30, 8'd255);
		random_branches(100);
		set_config(8'd8, 8'd4, 8'd20, 8'd7);
		random_branches(120);
	endtask

	// Result side holds off while branches keep coming, input must stall.
	task automatic test_backpressure();
		hold_request = 1'b1;
		random_branches(30);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		br_ch.valid <= 1'b0;
		br_ch.branch_addr <= '0;
		br_ch.taken <= 1'b0;
		mismatches = 0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		// shadow reset state
		for (int i = 0; i < ENTRIES; i++) begin
			base_ctr[i] = 2'd0;
			for (int t = 0; t < NTAGGED; t++) slots[t][i] = '{'0, 1'b0, 2'd0, 2'd0};
		end
		ghist = '0;
		alloc_lfsr = LFSR_SEED;
		reg_first_len = 8'd4;
		reg_ratio = 5'd2;
		reg_pc_bits = 5'd12;
		reg_alloc_prob = 8'd3;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_register_extremes();
		test_random_settings();
		test_backpressure();

		br_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
